// ----- hw/rtl/swsp_pkg.sv -----
// shared types and constants of the stopwatch slot pool
package swsp_pkg;

    localparam int SLOTS     = 16;
    localparam int CLAIMABLE = (SLOTS < 16) ? SLOTS : 16;
    localparam int AW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW        = $clog2(SLOTS + 1);

    localparam int TOTAL_W   = 32;
    localparam int SPAN_W    = 16;

    localparam logic [SPAN_W-1:0] SPAN_RESET = 16'd50000;

    localparam logic [2:0] OP_START    = 3'd0;
    localparam logic [2:0] OP_READ     = 3'd1;
    localparam logic [2:0] OP_RESTART  = 3'd2;
    localparam logic [2:0] OP_FREE     = 3'd3;
    localparam logic [2:0] OP_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  slot;
        logic [15:0] counter_reading;
    } t_cmd;

    typedef struct packed {
        logic [3:0]         slot_id;
        logic               no_space;
        logic [TOTAL_W-1:0] elapsed_total;
    } t_result;

endpackage

// ----- hw/rtl/swsp_ram.sv -----
// generic single-write, single-read ram with registered read data
module swsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/stopwatch_slot_pool.sv -----
// stopwatch slot pool: slot totals in ram, busy and valid flags in flops
// ops 0-4 walk every entry through the single ram port pair, then read the commanded slot
// and then respond; other op codes go straight to the response step
// busy clears with the strobe, so a new transaction is taken only after the last one ends
// results are strobed for one cycle and cannot be stalled by the receiver
// synchronous reset clears busy and valid flags and loads span 50000; no clearing pass
module stopwatch_slot_pool (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  swsp_pkg::t_cmd         i_cmd,
    output logic                   o_valid,
    output swsp_pkg::t_result      o_result,
    input  logic                   i_cfg_we,
    input  logic [15:0]            i_cfg_wdata
);
    import swsp_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_RDREQ = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_pend_addr, n_pend_addr;
    logic [SLOTS-1:0]   r_slot_busy, n_slot_busy;
    logic [SLOTS-1:0]   r_slot_valid, n_slot_valid;
    logic               r_valid, n_valid;
    t_result            r_result, n_result;
    t_cmd               r_cmd;
    logic [TOTAL_W-1:0] r_amount;
    logic [SPAN_W-1:0]  r_span;

    logic               accept;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [TOTAL_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [TOTAL_W-1:0] ram_rdata;
    logic [AW-1:0]      slot_idx;
    logic               slot_ok;
    logic               free_found;
    logic [AW-1:0]      free_idx;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign slot_idx = AW'(r_cmd.slot);
    assign slot_ok  = (32'(r_cmd.slot) < 32'(SLOTS));

    // lowest free slot among those a 4-bit index can name
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = CLAIMABLE - 1; i >= 0; i--) begin
            if (!r_slot_busy[i]) begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    swsp_ram #(
        .WIDTH (TOTAL_W),
        .DEPTH (SLOTS)
    ) u_total_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_pend       = 1'b0;
        n_pend_addr  = r_pend_addr;
        n_slot_busy  = r_slot_busy;
        n_slot_valid = r_slot_valid;
        n_valid      = 1'b0;
        n_result     = r_result;
        ram_raddr    = r_cnt[AW-1:0];

        // write-back half of the walk: busy entry read last cycle gets the amount added (an invalid one from zero)
        ram_waddr = r_pend_addr;
        ram_wdata = (r_slot_valid[r_pend_addr] ? ram_rdata : '0) + r_amount;
        ram_we    = r_pend && r_slot_busy[r_pend_addr];
        if (ram_we) begin
            n_slot_valid[r_pend_addr] = 1'b1;
        end

        case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (accept) begin
                    if (i_cmd.operation inside {[OP_START:OP_OVERFLOW]}) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_WALK: begin
                if (r_cnt < CW'(SLOTS)) begin
                    n_pend      = 1'b1;
                    n_pend_addr = r_cnt[AW-1:0];
                    n_cnt       = r_cnt + CW'(1);
                end else begin
                    n_state = S_RDREQ;
                end
            end
            S_RDREQ: begin
                ram_raddr = slot_idx;
                n_state   = S_RESP;
            end
            S_RESP: begin
                n_state                = S_IDLE;
                n_valid                = 1'b1;
                n_result.slot_id       = r_cmd.slot;
                n_result.no_space      = 1'b0;
                n_result.elapsed_total = '0;
                case (r_cmd.operation)
                    OP_START: begin
                        if (free_found) begin
                            n_slot_busy[free_idx]  = 1'b1;
                            n_slot_valid[free_idx] = 1'b0;
                            n_result.slot_id       = 4'(free_idx);
                        end else begin
                            n_result.slot_id  = '0;
                            n_result.no_space = 1'b1;
                        end
                    end
                    OP_READ: begin
                        if (slot_ok && r_slot_valid[slot_idx]) begin
                            n_result.elapsed_total = ram_rdata;
                        end
                    end
                    OP_RESTART: begin
                        // an invalid entry reads as zero
                        if (slot_ok) begin
                            n_slot_valid[slot_idx] = 1'b0;
                        end
                    end
                    OP_FREE: begin
                        if (slot_ok) begin
                            n_slot_busy[slot_idx] = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_pend       <= 1'b0;
            r_slot_busy  <= '0;
            r_slot_valid <= '0;
            r_valid      <= 1'b0;
            r_span       <= SPAN_RESET;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_pend       <= n_pend;
            r_slot_busy  <= n_slot_busy;
            r_slot_valid <= n_slot_valid;
            r_valid      <= n_valid;
            if (i_cfg_we) begin
                r_span <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr <= n_pend_addr;
        r_result    <= n_result;
        if (accept) begin
            r_cmd <= i_cmd;
            if (i_cmd.operation inside {[OP_START:OP_FREE]}) begin
                r_amount <= TOTAL_W'(i_cmd.counter_reading);
            end else begin
                r_amount <= TOTAL_W'(r_span);
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // walk write-back never hits the entry being read in the same cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && r_state == S_WALK && r_cnt < CW'(SLOTS)) |-> (ram_waddr != ram_raddr))
        else $error("walk read and write-back collide");

    // every result strobe comes from the response step and frees the block
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) |=> (o_valid && !busy))
        else $error("response step did not strobe a result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == S_RESP))
        else $error("result strobe without response step");

    // a full pool reports slot zero and leaves every claimable slot busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.no_space) |-> (o_result.slot_id == '0 &&
            r_slot_busy[CLAIMABLE-1:0] == '1))
        else $error("no_space reported with a free slot");

    // the walk ends after the last entry and moves on to the slot read
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_cnt == CW'(SLOTS)) |=> (r_state == S_RDREQ && !r_pend))
        else $error("walk did not finish cleanly");

endmodule
